[rtl/core/hafp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_pkg - shared types and constants for the Hammer-Aitoff projection core
// Fixed-point formats, pi constants, series divisors and reciprocals, and the
// structs that travel along the cell chains.
// ----------------------------------------------------------------------------
package hafp_pkg;

    localparam int ANGLE_FRAC_BITS = 29;
    localparam int SINGULAR_MARGIN = 1;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int OUT_W   = 36;
    localparam int SCALE_W = 32;
    localparam int CFG_W   = 32;
    localparam int RED_W   = 54;   // range-reduction remainder
    localparam int ROOT_W  = 31;
    localparam int QUO_W   = 31;
    localparam int RAD_W   = 62;   // radicand, Q60
    localparam int DVD_W   = 61;   // dividend, Q60
    localparam int HORNER_STEPS = 6;

    localparam int RSH_P    = ANGLE_FRAC_BITS - 10;
    localparam int RSH_L    = ANGLE_FRAC_BITS - 9;
    localparam int SCALE_SH = 58 - ANGLE_FRAC_BITS;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // register indexes
    localparam logic REG_ORIGIN_LAT = 1'b0;
    localparam logic REG_SCALE      = 1'b1;

    // quadrant codes (q mod 4)
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
    localparam logic [31:0] SQRT2_Q30     = 32'd1518500250;
    localparam logic [31:0] TWO_SQRT2_Q30 = 32'd3037000500;

    function automatic logic [63:0] pi_at(input int sh);
        logic [64:0] s;
        s = {1'b0, PI_Q62} + (65'd1 << (sh - 1));
        s = s >> sh;
        return s[63:0];
    endfunction

    localparam logic [63:0] HP_P    = pi_at(43 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HP_L    = pi_at(42 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI = pi_at(63 - ANGLE_FRAC_BITS);
    localparam logic [63:0] PI_F    = pi_at(62 - ANGLE_FRAC_BITS);

    // round half away from zero, v / 2^sh
    function automatic logic signed [63:0] rsr(input logic signed [63:0] v,
                                               input int sh);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? $signed(64'd0 - m) : $signed(m);
    endfunction

    function automatic logic [7:0] sin_div(input int i);
        case (i)
            0:       return 8'd6;
            1:       return 8'd20;
            2:       return 8'd42;
            3:       return 8'd72;
            4:       return 8'd110;
            default: return 8'd156;
        endcase
    endfunction

    function automatic logic [7:0] cos_div(input int i);
        case (i)
            0:       return 8'd2;
            1:       return 8'd12;
            2:       return 8'd30;
            3:       return 8'd56;
            4:       return 8'd90;
            default: return 8'd132;
        endcase
    endfunction

    // floor(2^32 / d) for the series divisors
    function automatic logic [31:0] recip(input logic [7:0] d);
        case (d)
            8'd2:    return 32'd2147483648;
            8'd6:    return 32'd715827882;
            8'd12:   return 32'd357913941;
            8'd20:   return 32'd214748364;
            8'd30:   return 32'd143165576;
            8'd42:   return 32'd102261126;
            8'd56:   return 32'd76695844;
            8'd72:   return 32'd59652323;
            8'd90:   return 32'd47721858;
            8'd110:  return 32'd39045157;
            8'd132:  return 32'd32537631;
            default: return 32'd27531841;
        endcase
    endfunction

    typedef struct packed {
        logic signed [31:0] r_p;
        logic [1:0]         q_p;
        logic signed [31:0] r_l;
        logic [1:0]         q_l;
        logic               ok;
    } hafp_side_t;

    typedef struct packed {
        logic [29:0] r2_p;
        logic [30:0] ts_p;
        logic [30:0] tc_p;
        logic [29:0] r2_l;
        logic [30:0] ts_l;
        logic [30:0] tc_l;
        hafp_side_t  side;
    } hafp_series_t;

    typedef struct packed {
        logic [RAD_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic signed [31:0] num_x;
        logic signed [31:0] num_y;
        logic               ok;
    } hafp_root_t;

    typedef struct packed {
        logic [DVD_W-1:0]  rem_x;
        logic [QUO_W-1:0]  quo_x;
        logic [DVD_W-1:0]  rem_y;
        logic [QUO_W-1:0]  quo_y;
        logic [ROOT_W-1:0] den;
        logic              neg_x;
        logic              neg_y;
        logic              ok;
    } hafp_quot_t;

endpackage
`default_nettype wire

[rtl/core/hafp_horner_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_horner_cell - one Horner step of the sine and cosine series
// t_new = 1 - round(round(r2*t) / d) for four lanes, three register stages.
// ----------------------------------------------------------------------------
module hafp_horner_cell
    import hafp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_vld,
    input  wire hafp_series_t din,
    output logic              out_vld,
    output hafp_series_t      dout
);

    localparam logic [7:0]  DS = sin_div(STEP);
    localparam logic [7:0]  DC = cos_div(STEP);
    localparam logic [7:0]  DIV [4] = '{DS, DC, DS, DC};
    localparam logic [31:0] REC [4] = '{recip(DS), recip(DC), recip(DS), recip(DC)};

    // lanes: 0 sin/lat, 1 cos/lat, 2 sin/lon, 3 cos/lon
    logic [60:0]  pa_next [4];
    logic [60:0]  pa_reg  [4];
    logic [31:0]  x_next  [4];
    logic [31:0]  x_reg   [4];
    logic [63:0]  pb_next [4];
    logic [63:0]  pb_reg  [4];
    logic [30:0]  t_new   [4];
    hafp_series_t sa_reg, sb_reg, out_next, out_reg;
    logic         vld_a_reg, vld_b_reg, vld_c_reg;

    always_comb
    begin
        pa_next[0] = 61'(din.r2_p) * 61'(din.ts_p);
        pa_next[1] = 61'(din.r2_p) * 61'(din.tc_p);
        pa_next[2] = 61'(din.r2_l) * 61'(din.ts_l);
        pa_next[3] = 61'(din.r2_l) * 61'(din.tc_l);
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            x_next[j]  = 32'((pa_reg[j] + 61'(32'h2000_0000)) >> 30)
                       + 32'(DIV[j] >> 1);
            pb_next[j] = 64'(x_next[j]) * 64'(REC[j]);
        end
    end

    // reciprocal estimate is low by at most one
    always_comb
    begin
        logic [31:0] qe;
        logic [31:0] rem;
        for (int j = 0; j < 4; j++)
        begin
            qe  = pb_reg[j][63:32];
            rem = x_reg[j] - qe * 32'(DIV[j]);
            if (rem >= 32'(DIV[j]))
            begin
                qe = qe + 32'd1;
            end
            t_new[j] = 31'(ONE_Q30 - qe);
        end
        out_next      = sb_reg;
        out_next.ts_p = t_new[0];
        out_next.tc_p = t_new[1];
        out_next.ts_l = t_new[2];
        out_next.tc_l = t_new[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_next;
            x_reg   <= x_next;
            pb_reg  <= pb_next;
            sa_reg  <= din;
            sb_reg  <= sa_reg;
            out_reg <= out_next;
        end
    end

    assign out_vld = vld_c_reg;
    assign dout    = out_reg;

endmodule
`default_nettype wire

[rtl/core/hafp_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_sqrt_cell - one result bit of the floor square root
// Tries root bit BIT against the running remainder, one register stage.
// ----------------------------------------------------------------------------
module hafp_sqrt_cell
    import hafp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_vld,
    input  wire hafp_root_t din,
    output logic            out_vld,
    output hafp_root_t      dout
);

    hafp_root_t out_next, out_reg;
    logic       vld_reg;

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    always_comb
    begin
        logic [63:0] trial;
        trial    = (64'(din.root) << (BIT + 1)) | (64'd1 << (2 * BIT));
        out_next = din;
        if (64'(din.rem) >= trial)
        begin
            out_next.rem  = RAD_W'(64'(din.rem) - trial);
            out_next.root = din.root | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_vld = vld_reg;
    assign dout    = out_reg;

endmodule
`default_nettype wire

[rtl/core/hafp_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_div_cell - one quotient bit of the restoring divider, two lanes
// Both easting and northing numerators share the same divisor.
// ----------------------------------------------------------------------------
module hafp_div_cell
    import hafp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_vld,
    input  wire hafp_quot_t din,
    output logic            out_vld,
    output hafp_quot_t      dout
);

    hafp_quot_t out_next, out_reg;
    logic       vld_reg;

    always_comb
    begin
        logic [63:0] dsh;
        dsh      = 64'(din.den) << BIT;
        out_next = din;
        if (64'(din.rem_x) >= dsh)
        begin
            out_next.rem_x = DVD_W'(64'(din.rem_x) - dsh);
            out_next.quo_x = din.quo_x | (QUO_W'(1) << BIT);
        end
        if (64'(din.rem_y) >= dsh)
        begin
            out_next.rem_y = DVD_W'(64'(din.rem_y) - dsh);
            out_next.quo_y = din.quo_y | (QUO_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_vld = vld_reg;
    assign dout    = out_reg;

endmodule
`default_nettype wire

[rtl/core/hammer_aitoff_forward_projection_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput is one point per clock while the output is not stalled: 5 front stages,
// 6 Horner cells of 3 stages, 4 combine stages, 31 square-root cells, 1 setup stage,
// 31 divider cells and 4 scaling stages, all advancing together on one shared stall.
// Reset clears all stage valid bits; origin_latitude resets to 0, scale_factor to 1.0.
// ----------------------------------------------------------------------------
// hammer_aitoff_forward_projection_core - spherical Hammer-Aitoff forward map
// Shifts latitude by the origin, evaluates sin/cos by reduced Taylor series,
// then root, divide and scale, with invalid-point and saturation handling.
// ----------------------------------------------------------------------------
module hammer_aitoff_forward_projection_core
    import hafp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // config write port
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [LAT_W-1:0]   latitude,
    input  wire logic [LON_W-1:0]   longitude,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [OUT_W-1:0]        map_x,
    output logic [OUT_W-1:0]        map_y,
    output logic                    point_valid
);

    localparam logic signed [63:0] HP_P_S   = $signed(HP_P);
    localparam logic signed [63:0] HP_L_S   = $signed(HP_L);
    localparam logic signed [63:0] QHI_P    = $signed(HP_P - (HP_P >> 1));
    localparam logic signed [63:0] QLO_P    = -$signed(HP_P >> 1);
    localparam logic signed [63:0] QHI_L    = $signed(HP_L - (HP_L >> 1));
    localparam logic signed [63:0] QLO_L    = -$signed(HP_L >> 1);
    localparam logic [35:0]        POS_MAX  = 36'h7_FFFF_FFFF;
    localparam logic [35:0]        NEG_MAX  = 36'h8_0000_0000;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [LAT_W-1:0]   origin_latitude_reg;
    logic [SCALE_W-1:0] scale_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_latitude_reg <= '0;
            scale_factor_reg    <= 32'h1000_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_LAT: origin_latitude_reg <= cfg_data[LAT_W-1:0];
                REG_SCALE:      scale_factor_reg    <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: whole pipeline stalls only when the output register
    // holds a result that is not being taken.
    // ------------------------------------------------------------------
    logic adv;
    logic out_vld_reg;

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // F1: latitude shift and invalid-point tests
    // ------------------------------------------------------------------
    logic signed [31:0] dphi_next, dphi_reg;
    logic signed [31:0] lam_reg;
    logic [32:0]        adp_c, alam_c;
    logic               ok1_next, ok1_reg, v1_reg;

    always_comb
    begin
        logic pole;
        logic sing;
        dphi_next = $signed({latitude[LAT_W-1], latitude})
                  - $signed({origin_latitude_reg[LAT_W-1], origin_latitude_reg});
        adp_c  = dphi_next[31] ? (33'd0 - {1'b1, dphi_next}) : {1'b0, dphi_next};
        alam_c = longitude[LON_W-1] ? (33'd0 - {1'b1, longitude}) : {1'b0, longitude};
        pole   = 64'(adp_c) > HALF_PI;
        sing   = (64'(adp_c) < 64'(SINGULAR_MARGIN))
              && (64'(alam_c) + 64'(SINGULAR_MARGIN) > PI_F);
        ok1_next = !pole && !sing;
    end

    // ------------------------------------------------------------------
    // F2: quadrant choice (q is -1, 0 or 1 for every defined point)
    // ------------------------------------------------------------------
    logic signed [RED_W-1:0] rem_p_next, rem_p_reg, rem_l_next, rem_l_reg;
    logic [1:0]              q_p_next, q_p_reg, q_l_next, q_l_reg;
    logic                    ok2_reg, v2_reg;

    always_comb
    begin
        logic signed [63:0] ax_p;
        logic signed [63:0] ax_l;
        ax_p = 64'(dphi_reg) <<< 20;
        ax_l = 64'(lam_reg) <<< 20;
        if (ax_p >= QHI_P)
        begin
            rem_p_next = RED_W'(ax_p - HP_P_S);
            q_p_next   = QUAD_1;
        end
        else if (ax_p < QLO_P)
        begin
            rem_p_next = RED_W'(ax_p + HP_P_S);
            q_p_next   = QUAD_3;
        end
        else
        begin
            rem_p_next = RED_W'(ax_p);
            q_p_next   = QUAD_0;
        end
        if (ax_l >= QHI_L)
        begin
            rem_l_next = RED_W'(ax_l - HP_L_S);
            q_l_next   = QUAD_1;
        end
        else if (ax_l < QLO_L)
        begin
            rem_l_next = RED_W'(ax_l + HP_L_S);
            q_l_next   = QUAD_3;
        end
        else
        begin
            rem_l_next = RED_W'(ax_l);
            q_l_next   = QUAD_0;
        end
    end

    // ------------------------------------------------------------------
    // F3: reduced angle to Q30;  F4: r squared;  F5: r2 in Q30
    // ------------------------------------------------------------------
    logic signed [31:0] r_p_reg, r_l_reg, r_p4_reg, r_l4_reg;
    logic [1:0]         q_p3_reg, q_l3_reg, q_p4_reg, q_l4_reg;
    logic               ok3_reg, ok4_reg, v3_reg, v4_reg;
    logic [60:0]        sq_p_reg, sq_l_reg;
    logic signed [63:0] sq_p_full, sq_l_full;
    hafp_series_t       ser_next, ser_reg;
    logic               v5_reg;

    always_comb
    begin
        sq_p_full = 64'(r_p_reg) * 64'(r_p_reg);
        sq_l_full = 64'(r_l_reg) * 64'(r_l_reg);
    end

    always_comb
    begin
        ser_next.r2_p     = 30'((62'(sq_p_reg) + 62'(32'h2000_0000)) >> 30);
        ser_next.r2_l     = 30'((62'(sq_l_reg) + 62'(32'h2000_0000)) >> 30);
        ser_next.ts_p     = 31'(ONE_Q30);
        ser_next.tc_p     = 31'(ONE_Q30);
        ser_next.ts_l     = 31'(ONE_Q30);
        ser_next.tc_l     = 31'(ONE_Q30);
        ser_next.side.r_p = r_p4_reg;
        ser_next.side.q_p = q_p4_reg;
        ser_next.side.r_l = r_l4_reg;
        ser_next.side.q_l = q_l4_reg;
        ser_next.side.ok  = ok4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dphi_reg  <= dphi_next;
            lam_reg   <= $signed(longitude);
            ok1_reg   <= ok1_next;

            rem_p_reg <= rem_p_next;
            rem_l_reg <= rem_l_next;
            q_p_reg   <= q_p_next;
            q_l_reg   <= q_l_next;
            ok2_reg   <= ok1_reg;

            r_p_reg   <= 32'(rsr(64'(rem_p_reg), RSH_P));
            r_l_reg   <= 32'(rsr(64'(rem_l_reg), RSH_L));
            q_p3_reg  <= q_p_reg;
            q_l3_reg  <= q_l_reg;
            ok3_reg   <= ok2_reg;

            sq_p_reg  <= 61'(sq_p_full);
            sq_l_reg  <= 61'(sq_l_full);
            r_p4_reg  <= r_p_reg;
            r_l4_reg  <= r_l_reg;
            q_p4_reg  <= q_p3_reg;
            q_l4_reg  <= q_l3_reg;
            ok4_reg   <= ok3_reg;

            ser_reg   <= ser_next;
        end
    end

    // ------------------------------------------------------------------
    // Horner chain: cell j evaluates series term 5-j
    // ------------------------------------------------------------------
    hafp_series_t ser_bus [HORNER_STEPS+1];
    logic         ser_vld [HORNER_STEPS+1];

    assign ser_bus[0] = ser_reg;
    assign ser_vld[0] = v5_reg;

    for (genvar g = 0; g < HORNER_STEPS; g++)
    begin : g_horner
        hafp_horner_cell #(
            .STEP (HORNER_STEPS - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (ser_vld[g]),
            .din     (ser_bus[g]),
            .out_vld (ser_vld[g+1]),
            .dout    (ser_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // P1: r * t_sin;  P2: quadrant fold to sin/cos
    // ------------------------------------------------------------------
    hafp_series_t       sfin;
    logic signed [63:0] psv_p_reg, psv_l_reg;
    logic [30:0]        tc_p_reg, tc_l_reg;
    logic [1:0]         q_p6_reg, q_l6_reg;
    logic               ok6_reg, v6_reg;

    assign sfin = ser_bus[HORNER_STEPS];

    logic signed [31:0] sp_next, cp_next, sl_next, cl_next;
    logic signed [31:0] sp_reg, cp_reg, sl_reg, cl_reg;
    logic               ok7_reg, v7_reg;

    always_comb
    begin
        logic signed [31:0] sv_p;
        logic signed [31:0] sv_l;
        logic signed [31:0] cv_p;
        logic signed [31:0] cv_l;
        sv_p = 32'(rsr(psv_p_reg, 30));
        sv_l = 32'(rsr(psv_l_reg, 30));
        cv_p = $signed({1'b0, tc_p_reg});
        cv_l = $signed({1'b0, tc_l_reg});
        case (q_p6_reg)
            QUAD_0:  begin sp_next = sv_p;  cp_next = cv_p;  end
            QUAD_1:  begin sp_next = cv_p;  cp_next = -sv_p; end
            QUAD_2:  begin sp_next = -sv_p; cp_next = -cv_p; end
            default: begin sp_next = -cv_p; cp_next = sv_p;  end
        endcase
        case (q_l6_reg)
            QUAD_0:  begin sl_next = sv_l;  cl_next = cv_l;  end
            QUAD_1:  begin sl_next = cv_l;  cl_next = -sv_l; end
            QUAD_2:  begin sl_next = -sv_l; cl_next = -cv_l; end
            default: begin sl_next = -cv_l; cl_next = sv_l;  end
        endcase
    end

    // ------------------------------------------------------------------
    // P3: cos(dphi) products;  P4: northing numerator, radicand and easting numerator
    // ------------------------------------------------------------------
    logic signed [63:0] cpcl_reg, cpsl_reg;
    logic signed [31:0] sp8_reg;
    logic               ok8_reg, v8_reg;
    hafp_root_t         root_next, root_reg;
    logic               v9_reg;

    always_comb
    begin
        logic signed [32:0] vrad;
        vrad = 33'(ONE_Q30) + 33'(rsr(cpcl_reg, 30));
        root_next.num_x = 32'(rsr(cpsl_reg, 30));
        root_next.num_y = sp8_reg;
        root_next.root  = '0;
        root_next.ok    = ok8_reg && (vrad > 33'sd0);
        root_next.rem   = vrad[32] ? '0 : (RAD_W'(vrad) << 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= ser_vld[HORNER_STEPS];
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psv_p_reg <= 64'(sfin.side.r_p) * $signed({33'd0, sfin.ts_p});
            psv_l_reg <= 64'(sfin.side.r_l) * $signed({33'd0, sfin.ts_l});
            tc_p_reg  <= sfin.tc_p;
            tc_l_reg  <= sfin.tc_l;
            q_p6_reg  <= sfin.side.q_p;
            q_l6_reg  <= sfin.side.q_l;
            ok6_reg   <= sfin.side.ok;

            sp_reg    <= sp_next;
            cp_reg    <= cp_next;
            sl_reg    <= sl_next;
            cl_reg    <= cl_next;
            ok7_reg   <= ok6_reg;

            cpcl_reg  <= 64'(cp_reg) * 64'(cl_reg);
            cpsl_reg  <= 64'(cp_reg) * 64'(sl_reg);
            sp8_reg   <= sp_reg;
            ok8_reg   <= ok7_reg;

            root_reg  <= root_next;
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain, one root bit per cell, MSB first
    // ------------------------------------------------------------------
    hafp_root_t root_bus [ROOT_W+1];
    logic       root_vld [ROOT_W+1];

    assign root_bus[0] = root_reg;
    assign root_vld[0] = v9_reg;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        hafp_sqrt_cell #(
            .BIT (ROOT_W - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (root_vld[g]),
            .din     (root_bus[g]),
            .out_vld (root_vld[g+1]),
            .dout    (root_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Q1: dividends (|num| << 30) + den/2 with rounding folded in
    // ------------------------------------------------------------------
    hafp_root_t rfin;
    hafp_quot_t quot_next, quot_reg;
    logic       v10_reg;

    assign rfin = root_bus[ROOT_W];

    always_comb
    begin
        logic [31:0] mx;
        logic [31:0] my;
        mx = rfin.num_x[31] ? (32'd0 - rfin.num_x) : rfin.num_x;
        my = rfin.num_y[31] ? (32'd0 - rfin.num_y) : rfin.num_y;
        quot_next.den   = rfin.root;
        quot_next.rem_x = (DVD_W'(mx) << 30) + DVD_W'(rfin.root >> 1);
        quot_next.rem_y = (DVD_W'(my) << 30) + DVD_W'(rfin.root >> 1);
        quot_next.quo_x = '0;
        quot_next.quo_y = '0;
        quot_next.neg_x = rfin.num_x[31];
        quot_next.neg_y = rfin.num_y[31];
        quot_next.ok    = rfin.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
        end
        else if (adv)
        begin
            v10_reg <= root_vld[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg <= quot_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain, one quotient bit per cell, MSB first
    // ------------------------------------------------------------------
    hafp_quot_t quot_bus [QUO_W+1];
    logic       quot_vld [QUO_W+1];

    assign quot_bus[0] = quot_reg;
    assign quot_vld[0] = v10_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        hafp_div_cell #(
            .BIT (QUO_W - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (quot_vld[g]),
            .din     (quot_bus[g]),
            .out_vld (quot_vld[g+1]),
            .dout    (quot_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // M1..M4: times sqrt2 constants, times k, saturate, sign, mask
    // ------------------------------------------------------------------
    hafp_quot_t  qfin;
    logic [62:0] pcx_reg, pcy_reg;
    logic [32:0] v1x_reg, v1y_reg;
    logic [64:0] pkx_reg, pky_reg;
    logic        ng11_x, ng11_y, ok11_reg, v11_reg;
    logic        ng12_x, ng12_y, ok12_reg, v12_reg;
    logic        ng13_x, ng13_y, ok13_reg, v13_reg;
    logic [OUT_W-1:0] map_x_next, map_y_next, map_x_reg, map_y_reg;
    logic             point_valid_reg;

    assign qfin = quot_bus[QUO_W];

    function automatic logic [OUT_W-1:0] finish(input logic [64:0] p, input logic neg);
        logic [65:0] v;
        v = (66'(p) + (66'd1 << (SCALE_SH - 1))) >> SCALE_SH;
        if (neg)
        begin
            if (v > 66'(NEG_MAX))
            begin
                v = 66'(NEG_MAX);
            end
            return OUT_W'(66'd0 - v);
        end
        if (v > 66'(POS_MAX))
        begin
            v = 66'(POS_MAX);
        end
        return OUT_W'(v);
    endfunction

    always_comb
    begin
        map_x_next = ok13_reg ? finish(pkx_reg, ng13_x) : '0;
        map_y_next = ok13_reg ? finish(pky_reg, ng13_y) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v11_reg     <= 1'b0;
            v12_reg     <= 1'b0;
            v13_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v11_reg     <= quot_vld[QUO_W];
            v12_reg     <= v11_reg;
            v13_reg     <= v12_reg;
            out_vld_reg <= v13_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pcx_reg  <= 63'(qfin.quo_x) * 63'(TWO_SQRT2_Q30);
            pcy_reg  <= 63'(qfin.quo_y) * 63'(SQRT2_Q30);
            ng11_x   <= qfin.neg_x;
            ng11_y   <= qfin.neg_y;
            ok11_reg <= qfin.ok;

            v1x_reg  <= 33'((pcx_reg + 63'(32'h2000_0000)) >> 30);
            v1y_reg  <= 33'((pcy_reg + 63'(32'h2000_0000)) >> 30);
            ng12_x   <= ng11_x;
            ng12_y   <= ng11_y;
            ok12_reg <= ok11_reg;

            pkx_reg  <= 65'(v1x_reg) * 65'(scale_factor_reg);
            pky_reg  <= 65'(v1y_reg) * 65'(scale_factor_reg);
            ng13_x   <= ng12_x;
            ng13_y   <= ng12_y;
            ok13_reg <= ok12_reg;

            map_x_reg       <= map_x_next;
            map_y_reg       <= map_y_next;
            point_valid_reg <= ok13_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign map_x       = map_x_reg;
    assign map_y       = map_y_reg;
    assign point_valid = point_valid_reg;

endmodule
`default_nettype wire
